/* design/stb_pkg.sv */
// Shared constants, field layout and control/status types for the software timer bank.
// Used by the controller, the datapath and the top level; depends on nothing.
package stb_pkg;

   // Number of timer slots and the width of a slot index inside the block.
   localparam int NUM_SLOTS = 16;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Field widths of the request and response words.
   localparam int MODE_W = 2;
   localparam int SLOT_W = 4;
   localparam int TICK_W = 12;
   localparam int TIME_W = 32;
   localparam int PAD_W  = TIME_W - TICK_W;

   // Request word: slot, elapsed ticks, start delay, reload period (from bit 0 up).
   localparam int REQ_USER_W  = MODE_W;
   localparam int REQ_FIELD_W = SLOT_W + TICK_W + TIME_W + TIME_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int ELAPSED_LSB = SLOT_W;
   localparam int DELAY_LSB   = SLOT_W + TICK_W;
   localparam int PERIOD_LSB  = SLOT_W + TICK_W + TIME_W;

   // Response word: fired slot, fire time (from bit 0 up), zero padded to bytes.
   localparam int RSP_FIELD_W = SLOT_W + TIME_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Request modes carried in tuser.
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;     // request word accepted this cycle
      logic advance;  // evaluate the current slot and step to the next one
      logic flush;    // send the held result as the last one of the tick
   } stb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_tick;   // incoming request is a tick
      logic fire;        // current slot is due
      logic out_free;    // output register can take a word this cycle
      logic idx_last;    // current slot is the highest one
      logic pend_valid;  // a fired result is held back
   } stb_status_type;

endpackage

/* design/stb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the slot deadline and period stores.
module stb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/stb_ctrl.sv */
// Controller state machine of the software timer bank: accepts words and sequences the scan.
// Depends on stb_pkg for the command and status types.
module stb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  stb_pkg::stb_status_type status,
   output stb_pkg::stb_cmd_type    cmd
);
   import stb_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRIME = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       advance;

   // A slot holds its place only when it must pass on a held result and the output is full.
   assign advance = !(status.fire && status.pend_valid && !status.out_free);

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.take    = 1'b0;
      cmd.advance = 1'b0;
      cmd.flush   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (status.item_tick) begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.advance = advance;
            if (advance && status.idx_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/stb_datapath.sv */
// Datapath of the software timer bank: time, slot stores, due test and output register.
// Depends on stb_pkg and instantiates stb_ram for deadlines and periods.
module stb_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  stb_pkg::stb_cmd_type              cmd,
   output stb_pkg::stb_status_type           status,
   input  logic [stb_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic [stb_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [stb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);
   import stb_pkg::*;

   // Request fields.
   logic [SLOT_W-1:0] req_slot;
   logic [TICK_W-1:0] req_elapsed;
   logic [TIME_W-1:0] req_delay;
   logic [TIME_W-1:0] req_period;
   logic              slot_ok;
   logic              do_start;
   logic              do_stop;
   logic              do_tick;
   logic [IDX_W-1:0]  req_idx;

   assign req_slot    = req_tdata[SLOT_W-1:0];
   assign req_elapsed = req_tdata[ELAPSED_LSB +: TICK_W];
   assign req_delay   = req_tdata[DELAY_LSB +: TIME_W];
   assign req_period  = req_tdata[PERIOD_LSB +: TIME_W];
   assign slot_ok     = (32'(req_slot) < NUM_SLOTS);
   assign req_idx     = IDX_W'(req_slot);
   assign do_start    = cmd.take && (req_tuser == MODE_START) && slot_ok;
   assign do_stop     = cmd.take && (req_tuser == MODE_STOP) && slot_ok;
   assign do_tick     = cmd.take && (req_tuser == MODE_TICK);

   // State registers.
   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    before_ff;
   logic [TICK_W-1:0]    delta_ff;
   logic [NUM_SLOTS-1:0] active_ff;
   logic [NUM_SLOTS-1:0] active_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     pend_ff;
   logic                 pend_valid_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [IDX_W-1:0]     rsp_slot_ff;
   logic [TIME_W-1:0]    rsp_time_ff;
   logic                 rsp_last_ff;

   // Slot stores.
   logic                 dl_we;
   logic [IDX_W-1:0]     dl_waddr;
   logic [TIME_W-1:0]    dl_wdata;
   logic [TIME_W-1:0]    dl_rdata;
   logic [TIME_W-1:0]    pd_rdata;
   logic [IDX_W-1:0]     rd_addr;

   // Due test on the slot under evaluation: wrap-safe distance from the previous time.
   logic [TIME_W-1:0] due_gap;
   logic              fire;
   logic              reload;
   logic              push_mid;
   logic              out_free;

   assign due_gap  = dl_rdata - before_ff;
   assign fire     = active_ff[idx_ff] && (due_gap <= {{PAD_W{1'b0}}, delta_ff});
   assign reload   = (pd_rdata != '0);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign push_mid = cmd.advance && fire && pend_valid_ff;

   // Read the next slot once the current one is done, else keep reading the same one.
   assign rd_addr = cmd.advance ? (idx_ff + IDX_W'(1)) : idx_ff;

   // Deadline write: arming from a start word, or reload of a firing periodic slot.
   always_comb begin
      dl_we    = 1'b0;
      dl_waddr = idx_ff;
      dl_wdata = dl_rdata + pd_rdata;
      if (do_start) begin
         dl_we    = 1'b1;
         dl_waddr = req_idx;
         dl_wdata = now_ff + req_delay;
      end else if (cmd.advance && fire && reload) begin
         dl_we = 1'b1;
      end
   end

   stb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_wdata),
      .rd_addr (rd_addr),
      .rd_data (dl_rdata)
   );

   stb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (do_start),
      .wr_addr (req_idx),
      .wr_data (req_period),
      .rd_addr (rd_addr),
      .rd_data (pd_rdata)
   );

   // Active bits: set by start, cleared by stop or by a one-shot firing.
   always_comb begin
      active_in = active_ff;
      if (do_start) begin
         active_in[req_idx] = 1'b1;
      end
      if (do_stop) begin
         active_in[req_idx] = 1'b0;
      end
      if (cmd.advance && fire && !reload) begin
         active_in[idx_ff] = 1'b0;
      end
   end

   // Output register valid: loaded by a push, cleared when the word is taken.
   always_comb begin
      if (push_mid || cmd.flush) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         active_ff     <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_tick) begin
            now_ff <= now_ff + {{PAD_W{1'b0}}, req_elapsed};
         end
         if (cmd.take) begin
            idx_ff <= '0;
         end else if (cmd.advance) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.advance && fire) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (do_tick) begin
         before_ff <= now_ff;
         delta_ff  <= req_elapsed;
      end
      if (cmd.advance && fire) begin
         pend_ff <= idx_ff;
      end
      if (push_mid || cmd.flush) begin
         rsp_slot_ff <= pend_ff;
         rsp_time_ff <= now_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   assign status.item_tick  = (req_tuser == MODE_TICK);
   assign status.fire       = fire;
   assign status.out_free   = out_free;
   assign status.idx_last   = (idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign status.pend_valid = pend_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_time_ff, SLOT_W'(rsp_slot_ff)});

endmodule

/* design/software_timer_bank.sv */
// Top level of the software timer bank: joins the controller and the datapath.
// Depends on stb_pkg, stb_ctrl, stb_datapath and stb_ram.
//
//   channel | direction | tdata                                  | side band
//   req     | in        | slot, elapsed, start delay, period     | tuser = mode
//   rsp     | out       | fired slot, fire time                  | tlast = last fired
//
// A start or stop word is accepted in the idle state and starts no scan. A tick word first
// loads the time, then waits for the first registered read of the slot stores, then scans one slot per
// cycle through the single read port of the deadline and period memories, then sends
// the last result. A stall on rsp holds the scan at the next due slot.
// Reset clears the time and all active bits; the slot stores are not cleared.
module software_timer_bank (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode
   input  logic [stb_pkg::REQ_USER_W-1:0] req_tuser,
   // slot[3:0], elapsed_ticks[15:4], start_delay[47:16], reload_period[79:48]
   input  logic [stb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // fired_slot[3:0], fire_time[35:4], zeros above
   output logic [stb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import stb_pkg::*;

   stb_cmd_type    cmd;
   stb_status_type status;

   stb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   stb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The last result of a tick is only sent when one is held and the output can take it.
   a_flush_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> (status.pend_valid && status.out_free))
      else $error("flush without a held result or with the output full");

   // A slot never overwrites a held result that could not be sent.
   a_push_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.advance && status.fire && status.pend_valid) |-> status.out_free)
      else $error("scan advanced past a due slot with the output full");

   // After a tick word is accepted, no further word is accepted until the scan ends.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == MODE_TICK)) |=> !req_tready)
      else $error("request accepted during a tick scan");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the software timer bank: directed and random words on req,
// every rsp word compared field by field against an in-bench timer model or a typed result.
// Depends on stb_pkg and software_timer_bank.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stb_pkg::*;

   // Mode code that the block must ignore.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 247;
   localparam int QUIET_WORDS  = 40;
   localparam int HOLD_AFTER   = 100;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PRINT_CAP    = 200;

   // One expected firing.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] fire_time;
      logic              last;
   } firing_type;

   // One row of the directed plan; typed_n < 0 means the timer model supplies the result.
   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [SLOT_W-1:0] slot;
      logic [TICK_W-1:0] elapsed;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      int                typed_n;
      logic [SLOT_W-1:0] typed_slot;
      logic [TIME_W-1:0] typed_time;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_USER_W-1:0] req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Timer model state.
   logic [TIME_W-1:0] model_now;
   logic              model_armed    [NUM_SLOTS];
   logic [TIME_W-1:0] model_deadline [NUM_SLOTS];
   logic [TIME_W-1:0] model_period   [NUM_SLOTS];
   firing_type        tick_firings   [NUM_SLOTS];

   firing_type   pending_firings [$];
   plan_row_type directed_plan   [$];
   firing_type   oldest;

   int  mismatches = 0;
   int  cycles     = 0;
   int  words_sent = 0;
   bit  quiet      = 1'b0;
   bit  hold_done  = 1'b0;

   software_timer_bank DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("MISMATCH at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   // Applies one word to the timer model and returns how many slots fire.
   function automatic int fire_due_slots(input logic [MODE_W-1:0] mode,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic [TICK_W-1:0] elapsed,
                                         input logic [TIME_W-1:0] delay,
                                         input logic [TIME_W-1:0] period);
      logic [TIME_W-1:0] prev;
      int                n;
      n = 0;
      case (mode)
         MODE_START: begin
            if (slot < NUM_SLOTS) begin
               model_deadline[slot] = model_now + delay;
               model_period[slot]   = period;
               model_armed[slot]    = 1'b1;
            end
         end
         MODE_STOP: begin
            if (slot < NUM_SLOTS)
               model_armed[slot] = 1'b0;
         end
         MODE_TICK: begin
            prev      = model_now;
            model_now = prev + TIME_W'(elapsed);
            // Wrap-safe window test, slots in ascending order.
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (model_armed[i] && (model_deadline[i] - prev) <= TIME_W'(elapsed)) begin
                  tick_firings[n].slot      = SLOT_W'(i);
                  tick_firings[n].fire_time = model_now;
                  tick_firings[n].last      = 1'b0;
                  n++;
                  if (model_period[i] != '0)
                     model_deadline[i] = model_deadline[i] + model_period[i];
                  else
                     model_armed[i] = 1'b0;
               end
            end
            if (n > 0)
               tick_firings[n-1].last = 1'b1;
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic void add_row(input logic [MODE_W-1:0] mode, input int slot,
                                   input int elapsed, input logic [TIME_W-1:0] delay,
                                   input logic [TIME_W-1:0] period, input int typed_n,
                                   input int typed_slot, input logic [TIME_W-1:0] typed_time);
      plan_row_type row;
      row.mode       = mode;
      row.slot       = SLOT_W'(slot);
      row.elapsed    = TICK_W'(elapsed);
      row.delay      = delay;
      row.period     = period;
      row.typed_n    = typed_n;
      row.typed_slot = SLOT_W'(typed_slot);
      row.typed_time = typed_time;
      directed_plan.push_back(row);
   endfunction

   // Offers one req word, waits for the handshake, then records what should come back.
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                            input logic [TICK_W-1:0] elapsed,
                            input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] period,
                            input int typed_n, input logic [SLOT_W-1:0] typed_slot,
                            input logic [TIME_W-1:0] typed_time);
      logic [REQ_DATA_W-1:0] word;
      firing_type            typed;
      int                    n;
      word                              = '0;
      word[SLOT_W-1:0]                  = slot;
      word[ELAPSED_LSB +: TICK_W]       = elapsed;
      word[DELAY_LSB +: TIME_W]         = delay;
      word[PERIOD_LSB +: TIME_W]        = period;
      req_tuser  <= mode;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      n = fire_due_slots(mode, slot, elapsed, delay, period);
      if (typed_n < 0) begin
         for (int i = 0; i < n; i++)
            pending_firings.push_back(tick_firings[i]);
      end else if (typed_n > 0) begin
         typed.slot      = typed_slot;
         typed.fire_time = typed_time;
         typed.last      = 1'b1;
         pending_firings.push_back(typed);
      end
      // Occasional gap on the sender side.
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Compare every accepted rsp word with the oldest expected firing.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_firings.size() == 0) begin
            report_mismatch($sformatf("unexpected word slot %0d time %0d last %0b",
                                      rsp_tdata[SLOT_W-1:0], rsp_tdata[SLOT_W +: TIME_W],
                                      rsp_tlast));
         end else begin
            oldest = pending_firings.pop_front();
            if (rsp_tdata[SLOT_W-1:0] !== oldest.slot)
               report_mismatch($sformatf("fired slot %0d, expected %0d",
                                         rsp_tdata[SLOT_W-1:0], oldest.slot));
            if (rsp_tdata[SLOT_W +: TIME_W] !== oldest.fire_time)
               report_mismatch($sformatf("fire time %0d, expected %0d",
                                         rsp_tdata[SLOT_W +: TIME_W], oldest.fire_time));
            if (rsp_tlast !== oldest.last)
               report_mismatch($sformatf("last flag %0b, expected %0b",
                                         rsp_tlast, oldest.last));
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off so the block backs up into req.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (!hold_done && words_sent >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int                scored;
      int                pick;
      logic [SLOT_W-1:0] slot;
      logic [TICK_W-1:0] elapsed;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= MODE_TICK;
      req_tdata  <= '0;
      model_now = '0;
      for (int i = 0; i < NUM_SLOTS; i++)
         model_armed[i] = 1'b0;

      // Directed plan: reset state, extremes, ignored words, re-arm, wrap-around deadlines.
      add_row(MODE_TICK,   0,    0, 32'd0,          32'd0,          0, 0,  32'd0);
      add_row(MODE_STOP,   3,    0, 32'd0,          32'd0,          0, 0,  32'd0);
      add_row(MODE_UNUSED, 15, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  0, 0,  32'd0);
      add_row(MODE_TICK,   0,    0, 32'd0,          32'd0,          0, 0,  32'd0);
      add_row(MODE_START,  0,    0, 32'd5,          32'd0,          0, 0,  32'd0);
      add_row(MODE_TICK,   0,    5, 32'd0,          32'd0,          1, 0,  32'd5);
      add_row(MODE_TICK,   0, 4095, 32'd0,          32'd0,          0, 0,  32'd0);
      add_row(MODE_START, 15,    0, 32'd0,          32'd0,          0, 0,  32'd0);
      add_row(MODE_TICK,   0,    0, 32'd0,          32'd0,          1, 15, 32'd4100);
      add_row(MODE_START,  1,    0, 32'hFFFF_FFFF,  32'hFFFF_FFFF, -1, 0,  32'd0);
      add_row(MODE_START,  2,    0, 32'd10,         32'd3,         -1, 0,  32'd0);
      add_row(MODE_START,  3,    0, 32'd10,         32'd1,         -1, 0,  32'd0);
      add_row(MODE_START,  3,    0, 32'd20,         32'd0,         -1, 0,  32'd0);
      add_row(MODE_START,  9,    0, 32'hFFFF_F000,  32'h0000_1000, -1, 0,  32'd0);
      add_row(MODE_TICK,   0,  100, 32'd0,          32'd0,         -1, 0,  32'd0);
      add_row(MODE_TICK,   0,   12, 32'd0,          32'd0,         -1, 0,  32'd0);
      add_row(MODE_STOP,   1,    0, 32'd0,          32'd0,         -1, 0,  32'd0);
      add_row(MODE_STOP,   2,    0, 32'd0,          32'd0,         -1, 0,  32'd0);
      add_row(MODE_START,  7,    0, 32'd1,          32'd1,         -1, 0,  32'd0);
      add_row(MODE_START,  8,    0, 32'd1,          32'd2,         -1, 0,  32'd0);
      add_row(MODE_TICK,   0, 4095, 32'd0,          32'd0,         -1, 0,  32'd0);
      add_row(MODE_START,  4,    0, 32'h8000_0000,  32'h5555_5555, -1, 0,  32'd0);
      add_row(MODE_TICK,   0, 2048, 32'd0,          32'd0,         -1, 0,  32'd0);
      add_row(MODE_STOP,   0,    0, 32'd0,          32'd0,         -1, 0,  32'd0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         send_word(directed_plan[i].mode, directed_plan[i].slot, directed_plan[i].elapsed,
                   directed_plan[i].delay, directed_plan[i].period, directed_plan[i].typed_n,
                   directed_plan[i].typed_slot, directed_plan[i].typed_time);

      // Random part: mostly arming slots and ticks, some stops and ignored words.
      scored = 0;
      while (scored < RANDOM_WORDS) begin
         quiet   = (scored >= RANDOM_WORDS - QUIET_WORDS);
         pick    = $urandom_range(0, 99);
         slot    = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
         elapsed = ($urandom_range(0, 9) < 7) ? TICK_W'($urandom_range(0, 300))
                                              : TICK_W'($urandom_range(0, 4095));
         if ($urandom_range(0, 9) < 7)
            delay = TIME_W'($urandom_range(0, 2000));
         else
            delay = $urandom;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: period = '0;
            5, 6, 7, 8:    period = $urandom;
            default:       period = TIME_W'($urandom_range(1, 1500));
         endcase
         if (pick < 30) begin
            send_word(MODE_TICK, SLOT_W'($urandom), elapsed, $urandom, $urandom,
                      -1, '0, '0);
            scored++;
         end else if (pick < 85) begin
            send_word(MODE_START, slot, TICK_W'($urandom), delay, period, -1, '0, '0);
            scored++;
         end else if (pick < 95) begin
            send_word(MODE_STOP, slot, TICK_W'($urandom), $urandom, $urandom,
                      -1, '0, '0);
            scored++;
         end else begin
            send_word(MODE_UNUSED, slot, TICK_W'($urandom), $urandom, $urandom,
                      -1, '0, '0);
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then allow one full scan for anything unexpected.
      while (pending_firings.size() != 0)
         @(posedge clock);
      repeat (NUM_SLOTS + 10) @(posedge clock);
      if (pending_firings.size() != 0)
         report_mismatch($sformatf("%0d firings never arrived", pending_firings.size()));

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
design/stb_pkg.sv
design/stb_ram.sv
design/stb_ctrl.sv
design/stb_datapath.sv
design/software_timer_bank.sv
tb/tb.sv
